// ===== sv/aip_pkg.sv =====
`default_nettype none
package aip_pkg;

  localparam int MAX_CHARS_DEFAULT = 256;
  localparam int BASE_W            = 6;
  localparam int DIGIT_W           = 6;
  localparam int VALUE_W           = 64;
  localparam int COUNT_OUT_W       = 9;
  localparam int QUEUE_DEPTH       = 4;
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;

  // register word index (paddr above the byte offset)
  localparam logic [APB_ADDR_W-3:0] REG_NUMBER_BASE = '0;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] RADIX_8    = 6'd8;
  localparam logic [BASE_W-1:0] RADIX_10   = 6'd10;
  localparam logic [BASE_W-1:0] RADIX_16   = 6'd16;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_LEAD,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic               last;
    logic               blank;
    logic               sign;
    logic               minus;
    logic               zero;
    logic               xmark;
    logic               alnum;
    logic [DIGIT_W-1:0] dval;
  } char_class_t;

endpackage
`default_nettype wire

// ===== sv/aip_char_if.sv =====
`default_nettype none
interface aip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

// ===== sv/aip_result_if.sv =====
`default_nettype none
interface aip_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] parsed_value;
  logic [8:0]         chars_consumed;
  logic               overflow_seen;

  modport source (output valid, output parsed_value, output chars_consumed,
                  output overflow_seen, input ready);
  modport sink (input valid, input parsed_value, input chars_consumed,
                input overflow_seen, output ready);
endinterface
`default_nettype wire

// ===== sv/aip_front.sv =====
`default_nettype none
module aip_front (
  aip_char_if.sink            in_ch,
  output logic                push_valid,
  output aip_pkg::char_class_t push_data,
  input  logic                push_ready
);
  import aip_pkg::*;

  logic [7:0] c;
  logic [7:0] ofs;
  logic       is_num;
  logic       is_lower;
  logic       is_upper;

  assign c          = in_ch.char_code;
  assign in_ch.ready = push_ready;
  assign push_valid = in_ch.valid;

  assign is_num   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_lower = (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
  assign is_upper = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);

  always_comb begin
    ofs = 8'd0;
    priority if (is_num) begin
      ofs = c - CH_ZERO;
    end else if (is_lower) begin
      ofs = c - CH_LOWER_A + LETTER_OFS;
    end else if (is_upper) begin
      ofs = c - CH_UPPER_A + LETTER_OFS;
    end else begin
      ofs = 8'd0;
    end
  end

  always_comb begin
    push_data.last  = in_ch.last_char;
    push_data.blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                      (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
    push_data.sign  = (c == CH_PLUS) || (c == CH_MINUS);
    push_data.minus = (c == CH_MINUS);
    push_data.zero  = (c == CH_ZERO);
    push_data.xmark = (c == CH_LOWER_X) || (c == CH_UPPER_X);
    push_data.alnum = is_num || is_lower || is_upper;
    push_data.dval  = ofs[DIGIT_W-1:0];
  end

endmodule
`default_nettype wire

// ===== sv/aip_queue.sv =====
`default_nettype none
module aip_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  input  aip_pkg::char_class_t push_data,
  output logic                 push_ready,
  output logic                 pop_valid,
  output aip_pkg::char_class_t pop_data,
  input  logic                 pop_ready
);
  import aip_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  char_class_t      slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/aip_back.sv =====
`default_nettype none
module aip_back #(
  parameter int MAX_CHARS = aip_pkg::MAX_CHARS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [aip_pkg::BASE_W-1:0]  number_base,
  input  logic                        pop_valid,
  input  aip_pkg::char_class_t        pop_data,
  output logic                        pop_ready,
  aip_result_if.source                out_ch
);
  import aip_pkg::*;

  localparam int CW    = $clog2(MAX_CHARS + 1);
  localparam int MAC_W = VALUE_W + BASE_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CHARS);

  phase_t              phase;
  phase_t              phase_next;
  logic                minus;
  logic                minus_next;
  logic [BASE_W-1:0]   radix;
  logic [BASE_W-1:0]   radix_next;
  logic [VALUE_W-1:0]  acc;
  logic [VALUE_W-1:0]  acc_next;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_next;
  logic                wrap;
  logic                wrap_next;

  char_class_t         cls;
  logic [1:0]          add;
  logic                take_digit;
  logic                done;
  logic [MAC_W-1:0]    mac;
  logic [CW:0]         cnt_sum;
  logic                fire;

  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  logic [COUNT_OUT_W-1:0] out_count;
  logic                out_wrap;

  assign cls       = pop_data;
  assign pop_ready = !out_valid || out_ch.ready;
  assign fire      = pop_valid && pop_ready;

  // one character step; done marks an early return from the step
  always_comb begin
    phase_next = phase;
    minus_next = minus;
    radix_next = radix;
    add        = 2'd0;
    take_digit = 1'b0;
    done       = 1'b0;

    if (phase == PH_SPACE) begin
      if (cls.blank) begin
        add  = 2'd1;
        done = 1'b1;
      end else begin
        phase_next = PH_LEAD;
        if (cls.sign) begin
          minus_next = cls.minus;
          add        = 2'd1;
          done       = 1'b1;
        end
      end
    end

    if (!done && phase_next == PH_LEAD) begin
      if (number_base == BASE_AUTO) begin
        if (cls.zero) begin
          radix_next = RADIX_8;
          phase_next = PH_ZERO;
          done       = 1'b1;
        end else begin
          radix_next = RADIX_10;
        end
      end else if (number_base == RADIX_16 && cls.zero) begin
        radix_next = RADIX_16;
        phase_next = PH_ZERO;
        done       = 1'b1;
      end else begin
        radix_next = number_base;
      end
      if (!done) begin
        phase_next = PH_DIGITS;
      end
    end

    // pending '0': an x completes the hex prefix, otherwise the '0' was a digit
    if (!done && phase_next == PH_ZERO) begin
      phase_next = PH_DIGITS;
      if (cls.xmark) begin
        radix_next = RADIX_16;
        add        = 2'd2;
        done       = 1'b1;
      end else begin
        add = 2'd1;
      end
    end

    if (!done && phase_next == PH_DIGITS) begin
      if (!cls.alnum || cls.dval >= radix_next || radix_next == '0) begin
        phase_next = PH_DONE;
      end else begin
        take_digit = 1'b1;
        add        = add + 2'd1;
      end
    end

    // string ends on a pending '0'
    if (cls.last && phase_next == PH_ZERO) begin
      add = add + 2'd1;
    end
  end

  always_comb begin
    mac       = MAC_W'(acc) * MAC_W'(radix_next) + MAC_W'(cls.dval);
    acc_next  = take_digit ? mac[VALUE_W-1:0] : acc;
    wrap_next = wrap || (take_digit && (|mac[MAC_W-1:VALUE_W]));
    cnt_sum   = {1'b0, cnt} + (CW + 1)'(add);
    cnt_next  = (cnt_sum > (CW + 1)'(MAX_CHARS)) ? CNT_MAX : cnt_sum[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SPACE;
      minus <= 1'b0;
      radix <= '0;
      acc   <= '0;
      cnt   <= '0;
      wrap  <= 1'b0;
    end else if (fire) begin
      if (cls.last) begin
        phase <= PH_SPACE;
        minus <= 1'b0;
        radix <= '0;
        acc   <= '0;
        cnt   <= '0;
        wrap  <= 1'b0;
      end else begin
        phase <= phase_next;
        minus <= minus_next;
        radix <= radix_next;
        acc   <= acc_next;
        cnt   <= cnt_next;
        wrap  <= wrap_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && cls.last) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cls.last) begin
      out_value <= minus_next ? (VALUE_W'(0) - acc_next) : acc_next;
      out_count <= COUNT_OUT_W'(cnt_next);
      out_wrap  <= wrap_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.parsed_value   = out_value;
  assign out_ch.chars_consumed = out_count;
  assign out_ch.overflow_seen  = out_wrap;

endmodule
`default_nettype wire

// ===== sv/ascii_integer_parser_core.sv =====
// ascii_integer_parser_core: streaming string-to-integer converter.
// Input channel in_ch carries one character per beat (char_code, last_char).
// Leading blanks and one sign are skipped, the radix comes from number_base
// (0 picks it from a 0x / 0 prefix), and digits accumulate until the first
// character that is not a digit of the radix. Output channel out_ch carries
// one beat per string, after the beat with last_char set: the signed 64-bit
// value (wrapping), the consumed character count and the overflow flag.
// Throughput: one character per cycle while out_ch is not stalled; the front
// classifies each character and the back does one 64x6 multiply-add per cycle on
// the accumulator. The last character passes through the four-entry queue between
// front and back; once the back takes it, out_ch.valid is registered, and each
// character still queued ahead of it delays the result. When out_ch stalls, the
// back holds its result and the queue keeps taking up to four more characters
// before in_ch.ready drops. number_base is written over APB (byte address 0,
// reset 10); the user must write it only while the block is idle, which the
// block itself does not enforce. Synchronous reset clears the queue, the parse
// state and the output register; number_base returns to 10.
`default_nettype none
module ascii_integer_parser_core #(
  parameter int MAX_CHARS = aip_pkg::MAX_CHARS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [aip_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [aip_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [aip_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  aip_char_if.sink                         in_ch,
  aip_result_if.source                     out_ch
);
  import aip_pkg::*;

  logic [BASE_W-1:0] number_base;
  logic              reg_hit;
  logic              cfg_write;
  logic              push_valid;
  logic              push_ready;
  char_class_t       push_data;
  logic              pop_valid;
  logic              pop_ready;
  char_class_t       pop_data;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_NUMBER_BASE);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? APB_DATA_W'(number_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
    end else if (cfg_write) begin
      number_base <= pwdata[BASE_W-1:0];
    end
  end

  aip_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  aip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  aip_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .number_base (number_base),
    .pop_valid   (pop_valid),
    .pop_data    (pop_data),
    .pop_ready   (pop_ready),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

// ===== sv/aip_checker.sv =====
`default_nettype none
module aip_checker #(
  parameter int MAX_CHARS = aip_pkg::MAX_CHARS_DEFAULT
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [aip_pkg::APB_ADDR_W-1:0] paddr,
  input logic [aip_pkg::APB_DATA_W-1:0] pwdata,
  input logic [aip_pkg::APB_DATA_W-1:0] prdata,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [8:0]                     out_count,
  input logic                           out_overflow
);
  import aip_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (MAX_CHARS > 511) || (int'(out_count) <= MAX_CHARS))
    else $error("consumed count above saturation limit");

  // wrapping 64 bits takes at least eleven digits in any radix below 64
  a_wrap_needs_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_overflow |-> (MAX_CHARS > 511) || (out_count >= 9'd11))
    else $error("overflow reported on a short string");

  a_base_readback: assert property (@(posedge clk) disable iff (rst)
    $past(psel && penable && pwrite && !rst) && ($past(paddr[APB_ADDR_W-1:2]) ==
      REG_NUMBER_BASE) && (paddr[APB_ADDR_W-1:2] == REG_NUMBER_BASE)
      |-> prdata[BASE_W-1:0] == $past(pwdata[BASE_W-1:0]))
    else $error("number_base readback mismatch");

endmodule

bind ascii_integer_parser_core aip_checker #(
  .MAX_CHARS (MAX_CHARS)
) u_aip_checker (
  .clk          (clk),
  .rst          (rst),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_count    (out_ch.chars_consumed),
  .out_overflow (out_ch.overflow_seen)
);
`default_nettype wire
